>>> hdl/asv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asv_pkg
// Shared types and codes for the arrival steering velocity core.
// ----------------------------------------------------------------------------
package asv_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_RAD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_RAD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE      = 3'd4;

    // Operand selection of the shared multiplier, one product per step
    typedef enum logic [2:0] {
        MUL_DX   = 3'd0,
        MUL_DY   = 3'd1,
        MUL_LX   = 3'd2,
        MUL_LY   = 3'd3,
        MUL_RAD  = 3'd4,
        MUL_FX   = 3'd5,
        MUL_FY   = 3'd6,
        MUL_NONE = 3'd7
    } t_mul_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic     diff;
        logic     mul;
        t_mul_sel mul_sel;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     div_prep;
        logic     div_step;
        logic     out_load;
    } t_cmd;

endpackage

>>> hdl/asv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asv_pos_if / asv_vel_if
// Valid/ready channels for agent positions and velocity results.
// ----------------------------------------------------------------------------
interface asv_pos_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface asv_vel_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vel_x;
    logic signed [COORD_WIDTH-1:0] vel_y;
    logic                          entered_radius;

    modport source (output valid, output vel_x, output vel_y, output entered_radius,
                    input ready);
    modport sink   (input valid, input vel_x, input vel_y, input entered_radius,
                    output ready);
endinterface

>>> hdl/asv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asv_ctrl
// Sequencer: offsets, multiply steps, square root, divide, result hand-off.
// ----------------------------------------------------------------------------
module asv_ctrl #(
    parameter int COORD_WIDTH = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output asv_pkg::t_cmd o_cmd
);
    localparam int CNT_W = $clog2(COORD_WIDTH + 2);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIFF = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_SQRT = 7'b0001000,
        ST_DIVP = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_DONE = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state, step counter and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.mul_sel = asv_pkg::MUL_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_cnt      = '0;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul     = 1'b1;
                o_cmd.mul_sel = asv_pkg::t_mul_sel'(r_cnt[2:0]);
                n_cnt         = r_cnt + 1'b1;
                if (asv_pkg::t_mul_sel'(r_cnt[2:0]) == asv_pkg::MUL_FY) begin
                    o_cmd.sqrt_init = 1'b1;
                    n_cnt           = '0;
                    n_state         = ST_SQRT;
                end
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(COORD_WIDTH)) begin
                    n_state = ST_DIVP;
                end
            end
            ST_DIVP: begin
                o_cmd.div_prep = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(COORD_WIDTH - 2)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

>>> hdl/asv_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asv_dp
// Datapath: config registers, shared multiplier, root and divide units.
// ----------------------------------------------------------------------------
module asv_dp #(
    parameter int COORD_WIDTH = 24,
    parameter logic [COORD_WIDTH-2:0] SLOW_RST   = '0,
    parameter logic [COORD_WIDTH-2:0] ARRIVE_RST = '0,
    parameter logic [COORD_WIDTH-2:0] FORCE_RST  = '0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [asv_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]            i_cfg_data,
    input  logic                              i_in_xfer,
    input  logic signed [COORD_WIDTH-1:0]     i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]     i_pos_y,
    input  asv_pkg::t_cmd                     i_cmd,
    output logic signed [COORD_WIDTH-1:0]     o_vel_x,
    output logic signed [COORD_WIDTH-1:0]     o_vel_y,
    output logic                              o_entered_radius
);
    localparam int W  = COORD_WIDTH;
    localparam int MW = W + 1;       // offset magnitude
    localparam int PW = 2 * W + 2;   // products and sums of squares
    localparam int RW = W + 4;       // root remainder
    localparam int QW = W - 1;       // unsaturated quotient

    // Configuration
    logic signed [W-1:0] r_tx, r_ty;
    logic [W-2:0]        r_slow, r_arrive, r_force;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx     <= '0;
            r_ty     <= '0;
            r_slow   <= SLOW_RST;
            r_arrive <= ARRIVE_RST;
            r_force  <= FORCE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                asv_pkg::CFG_TARGET_X:   r_tx     <= i_cfg_data;
                asv_pkg::CFG_TARGET_Y:   r_ty     <= i_cfg_data;
                asv_pkg::CFG_SLOW_RAD:   r_slow   <= i_cfg_data[W-2:0];
                asv_pkg::CFG_ARRIVE_RAD: r_arrive <= i_cfg_data[W-2:0];
                asv_pkg::CFG_FORCE:      r_force  <= i_cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // Position capture and previous position
    logic signed [W-1:0] r_px, r_py, r_prev_x, r_prev_y;

    always_ff @(posedge i_clk) begin
        if (i_in_xfer) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else if (i_cmd.diff) begin
            r_prev_x <= r_px;
            r_prev_y <= r_py;
        end
    end

    // Offsets to the target, split into sign and magnitude
    logic signed [MW-1:0] dx_s, dy_s, lx_s, ly_s;
    logic [MW-1:0]        r_mdx, r_mdy, r_mlx, r_mly;
    logic                 r_ndx, r_ndy;

    assign dx_s = $signed({r_tx[W-1], r_tx}) - $signed({r_px[W-1], r_px});
    assign dy_s = $signed({r_ty[W-1], r_ty}) - $signed({r_py[W-1], r_py});
    assign lx_s = $signed({r_tx[W-1], r_tx}) - $signed({r_prev_x[W-1], r_prev_x});
    assign ly_s = $signed({r_ty[W-1], r_ty}) - $signed({r_prev_y[W-1], r_prev_y});

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_mdx <= dx_s[MW-1] ? MW'(-dx_s) : MW'(dx_s);
            r_mdy <= dy_s[MW-1] ? MW'(-dy_s) : MW'(dy_s);
            r_mlx <= lx_s[MW-1] ? MW'(-lx_s) : MW'(lx_s);
            r_mly <= ly_s[MW-1] ? MW'(-ly_s) : MW'(ly_s);
            r_ndx <= dx_s[MW-1];
            r_ndy <= dy_s[MW-1];
        end
    end

    // Shared multiplier, one product per step, accumulated a step later
    logic [MW-1:0]     mul_a, mul_b;
    logic [PW-1:0]     r_prod;
    asv_pkg::t_mul_sel r_prod_sel;
    logic              r_prod_vld;
    logic [PW-1:0]     r_cur, r_last, r_rad2, r_nx, r_ny;

    always_comb begin
        unique case (i_cmd.mul_sel)
            asv_pkg::MUL_DX:  begin mul_a = r_mdx;             mul_b = r_mdx; end
            asv_pkg::MUL_DY:  begin mul_a = r_mdy;             mul_b = r_mdy; end
            asv_pkg::MUL_LX:  begin mul_a = r_mlx;             mul_b = r_mlx; end
            asv_pkg::MUL_LY:  begin mul_a = r_mly;             mul_b = r_mly; end
            asv_pkg::MUL_RAD: begin mul_a = MW'(r_arrive);     mul_b = MW'(r_arrive); end
            asv_pkg::MUL_FX:  begin mul_a = r_mdx;             mul_b = MW'(r_force); end
            asv_pkg::MUL_FY:  begin mul_a = r_mdy;             mul_b = MW'(r_force); end
            default:          begin mul_a = '0;                mul_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod     <= mul_a * mul_b;
            r_prod_sel <= i_cmd.mul_sel;
        end
    end

    // Route each product to its sum or result register
    always_ff @(posedge i_clk) begin
        if (r_prod_vld) begin
            unique case (r_prod_sel)
                asv_pkg::MUL_DX:  r_cur  <= r_prod;
                asv_pkg::MUL_DY:  r_cur  <= r_cur + r_prod;
                asv_pkg::MUL_LX:  r_last <= r_prod;
                asv_pkg::MUL_LY:  r_last <= r_last + r_prod;
                asv_pkg::MUL_RAD: r_rad2 <= r_prod;
                asv_pkg::MUL_FX:  r_nx   <= r_prod;
                asv_pkg::MUL_FY:  r_ny   <= r_prod;
                default: ;
            endcase
        end
    end

    // Integer square root, one result bit per step
    logic [PW-1:0] r_src;
    logic [RW-1:0] r_rem;
    logic [MW-1:0] r_root;
    logic [RW-1:0] rem_sh, trial;

    assign rem_sh = {r_rem[RW-3:0], r_src[PW-1:PW-2]};
    assign trial  = RW'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_src  <= r_cur;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_src <= r_src << 2;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[MW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[MW-2:0], 1'b0};
            end
        end
    end

    // Divisor, saturation checks and arrival flag
    logic [MW-1:0] divisor;
    logic [PW-1:0] sat_lim;
    logic          r_zero, r_satx, r_saty, r_arr;

    assign divisor = (r_root > MW'(r_slow)) ? r_root : MW'(r_slow);
    assign sat_lim = PW'(divisor) << (W - 1);

    // Restoring divide, both components side by side
    logic [PW-1:0] r_remx, r_remy, r_dsh;
    logic [QW-1:0] r_qx, r_qy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_prep) begin
            r_zero <= (divisor == '0);
            r_satx <= (r_nx >= sat_lim);
            r_saty <= (r_ny >= sat_lim);
            r_arr  <= (r_last > r_rad2) && (r_cur <= r_rad2);
            r_remx <= r_nx;
            r_remy <= r_ny;
            r_dsh  <= PW'(divisor) << (W - 2);
            r_qx   <= '0;
            r_qy   <= '0;
        end else if (i_cmd.div_step) begin
            r_dsh <= r_dsh >> 1;
            if (r_remx >= r_dsh) begin
                r_remx <= r_remx - r_dsh;
                r_qx   <= {r_qx[QW-2:0], 1'b1};
            end else begin
                r_qx   <= {r_qx[QW-2:0], 1'b0};
            end
            if (r_remy >= r_dsh) begin
                r_remy <= r_remy - r_dsh;
                r_qy   <= {r_qy[QW-2:0], 1'b1};
            end else begin
                r_qy   <= {r_qy[QW-2:0], 1'b0};
            end
        end
    end

    // Apply sign, saturation and zero divisor
    function automatic logic [W-1:0] f_vel(input logic zero, input logic sat,
                                           input logic neg, input logic [QW-1:0] q);
        logic [W-1:0] q_ext;
        q_ext = {1'b0, q};
        if (zero) begin
            f_vel = '0;
        end else if (sat) begin
            f_vel = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            f_vel = neg ? (~q_ext + 1'b1) : q_ext;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_vel_x          <= f_vel(r_zero, r_satx, r_ndx, r_qx);
            o_vel_y          <= f_vel(r_zero, r_saty, r_ndy, r_qy);
            o_entered_radius <= r_arr;
        end
    end
endmodule

>>> hdl/arrival_steering_velocity_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrival_steering_velocity_core
// Arrival steering: velocity toward a target, slowing inside a radius.
// ----------------------------------------------------------------------------
// Usage:
//   i_pos carries one agent position (pos_x, pos_y) per transfer; o_vel
//   returns one result (vel_x, vel_y, entered_radius) for each position.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
//   user must write them only while the core is idle; the core itself does
//   not enforce this. Indexes past the force strength are ignored. Steps,
//   in order: an offset step, seven steps of the shared multiplier,
//   COORD_WIDTH+1 steps of the bit-serial square root, a divisor step,
//   COORD_WIDTH-1 steps of the dual restoring divider and a load step.
//   One position is processed at a time; i_pos.ready rises as soon as the
//   result sits in the output register, so the next position is taken while
//   the previous result waits. A stalled receiver holds the result; a
//   finished item then waits until the output register frees.
//   Reset (synchronous, active low) restores the register defaults, clears
//   the stored previous position and empties the output register.
// ----------------------------------------------------------------------------
module arrival_steering_velocity_core #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    asv_pos_if.sink                           i_pos,
    asv_vel_if.source                         o_vel,
    input  logic                              i_cfg_we,
    input  logic [asv_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]            i_cfg_data
);
    localparam logic [COORD_WIDTH-2:0] SLOW_RST   = (COORD_WIDTH-1)'(100 << FRAC_BITS);
    localparam logic [COORD_WIDTH-2:0] ARRIVE_RST = (COORD_WIDTH-1)'(10 << FRAC_BITS);
    localparam logic [COORD_WIDTH-2:0] FORCE_RST  = (COORD_WIDTH-1)'(100 << FRAC_BITS);

    asv_pkg::t_cmd cmd;
    logic          in_xfer;

    assign in_xfer = i_pos.valid && i_pos.ready;

    asv_ctrl #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pos.valid),
        .o_in_ready  (i_pos.ready),
        .i_out_ready (o_vel.ready),
        .o_out_valid (o_vel.valid),
        .o_cmd       (cmd)
    );

    asv_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .SLOW_RST    (SLOW_RST),
        .ARRIVE_RST  (ARRIVE_RST),
        .FORCE_RST   (FORCE_RST)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_xfer        (in_xfer),
        .i_pos_x          (i_pos.pos_x),
        .i_pos_y          (i_pos.pos_y),
        .i_cmd            (cmd),
        .o_vel_x          (o_vel.vel_x),
        .o_vel_y          (o_vel.vel_y),
        .o_entered_radius (o_vel.entered_radius)
    );

    // Input transfer starts the offset step next cycle
    a_xfer_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> cmd.diff)
        else $error("input transfer did not start processing");

    // Loading a result raises output valid
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_vel.valid)
        else $error("result load without output valid");

    // Never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_vel.valid && !o_vel.ready))
        else $error("pending result overwritten");

    // No new position while an item is in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.mul || cmd.sqrt_step || cmd.div_step) |-> !i_pos.ready)
        else $error("input ready while busy");
endmodule
